FILE: hw/rtl/ttyle_pkg.sv
// shared types and constants for the tty line edit buffer
`default_nettype none

package ttyle_pkg;

  localparam int RING_DEPTH_DEF = 64;
  localparam int CHAR_W         = 8;
  localparam int CFG_IDX_W      = 4;

  localparam logic [CHAR_W-1:0] CH_INTR = 8'h03;
  localparam logic [CHAR_W-1:0] CH_EOF  = 8'h04;
  localparam logic [CHAR_W-1:0] CH_BS   = 8'h08;
  localparam logic [CHAR_W-1:0] CH_NL   = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_CR   = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_KILL = 8'h15;
  localparam logic [CHAR_W-1:0] CH_DEL  = 8'h7F;
  localparam logic [CHAR_W-1:0] CH_NUL  = 8'h00;

  localparam logic [CHAR_W-1:0] BS_CODE_RST = 8'h08;

  localparam logic [CFG_IDX_W-1:0] REG_BS_CODE = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HAS_FG  = 4'd1;

  localparam logic ACT_RECEIVE = 1'b0;
  localparam logic ACT_READ    = 1'b1;

  typedef enum logic [2:0] {
    KIND_ECHO  = 3'd0,
    KIND_INTR  = 3'd1,
    KIND_BYTE  = 3'd2,
    KIND_EOF   = 3'd3,
    KIND_EMPTY = 3'd4,
    KIND_NONE  = 3'd5
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RD_WAIT,
    ST_KILL_ADDR,
    ST_KILL_CHK
  } state_t;

endpackage

`default_nettype wire

FILE: hw/rtl/ttyle_if.sv
// channel interfaces: input items, result items and configuration writes
`default_nettype none

interface ttyle_in_if;
  import ttyle_pkg::*;
  logic              valid;
  logic              ready;
  logic              action;
  logic [CHAR_W-1:0] char_in;
  logic              read_started;
  modport source (output valid, action, char_in, read_started, input ready);
  modport sink (input valid, action, char_in, read_started, output ready);
endinterface

interface ttyle_out_if;
  import ttyle_pkg::*;
  logic              valid;
  logic              ready;
  kind_t             kind;
  logic [CHAR_W-1:0] data;
  logic              line_end;
  logic              wake_readers;
  logic              last;
  modport source (output valid, kind, data, line_end, wake_readers, last, input ready);
  modport sink (input valid, kind, data, line_end, wake_readers, last, output ready);
endinterface

interface ttyle_cfg_if;
  import ttyle_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CHAR_W-1:0]    wdata;
  modport source (output valid, index, wdata, input ready);
  modport sink (input valid, index, wdata, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/tty_line_edit_buffer_core.sv
// Canonical-mode line editor over a byte ring with read, commit and edit
// positions. Receive, backspace and interrupt items load their single result
// into the output register in the next cycle; a read that finds committed
// bytes passes through a read-wait state because the ring sits in a RAM with
// a registered read port, and a read of an empty ring loads its result
// directly. A kill-line item walks back through the uncommitted text on that
// same read port, an address and a check state per erased byte, and emits
// one backspace echo per erased byte. The input is not ready while an item
// is in flight or while its result waits in the output register. The ring is
// not cleared after reset; the position order never reads an unwritten entry.
`default_nettype none

module tty_line_edit_buffer_core
  import ttyle_pkg::*;
#(
  parameter int RING_DEPTH = RING_DEPTH_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  ttyle_in_if.sink       in_ch,
  ttyle_out_if.source    out_ch,
  ttyle_cfg_if.sink      cfg_ch
);

  localparam int SPAN = 2 * RING_DEPTH;
  localparam int PW   = $clog2(SPAN);
  localparam int SW   = $clog2(RING_DEPTH);
  localparam int NW   = $clog2(RING_DEPTH + 1);

  function automatic logic [PW-1:0] pos_inc(input logic [PW-1:0] p);
    return (p == PW'(SPAN - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [PW-1:0] pos_dec(input logic [PW-1:0] p);
    return (p == '0) ? PW'(SPAN - 1) : p - 1'b1;
  endfunction

  function automatic logic [SW-1:0] pos_slot(input logic [PW-1:0] p);
    logic [PW-1:0] q;
    q = (p >= PW'(RING_DEPTH)) ? p - PW'(RING_DEPTH) : p;
    return q[SW-1:0];
  endfunction

  function automatic logic [PW:0] pos_diff(input logic [PW-1:0] a, input logic [PW-1:0] b);
    return (a >= b) ? {1'b0, a} - {1'b0, b}
                    : {1'b0, a} + (PW+1)'(SPAN) - {1'b0, b};
  endfunction

  state_t state_r, state_nxt;

  logic [PW-1:0] read_r, read_nxt;
  logic [PW-1:0] commit_r, commit_nxt;
  logic [PW-1:0] edit_r, edit_nxt;
  logic [NW-1:0] kill_cnt_r, kill_cnt_nxt;
  logic          started_r, started_nxt;

  logic [CHAR_W-1:0] bs_code_r;
  logic              has_fg_r;

  logic              out_valid_r;
  kind_t             out_kind_r;
  logic [CHAR_W-1:0] out_data_r;
  logic              out_line_end_r;
  logic              out_wake_r;
  logic              out_last_r;

  logic              load_out;
  kind_t             kind_nxt;
  logic [CHAR_W-1:0] data_nxt;
  logic              line_end_nxt;
  logic              wake_nxt;
  logic              last_nxt;

  logic              ram_we;
  logic [SW-1:0]     ram_raddr;
  logic [CHAR_W-1:0] ram_rdata;

  logic              out_free;
  logic              in_ready;
  logic              in_fire;
  logic              is_read;
  logic [CHAR_W-1:0] rx_char;
  logic [PW-1:0]     edit_inc;
  logic              has_room;
  logic              fills_ring;
  logic              pending;
  logic              ring_empty;
  logic              kill_go;
  logic              kill_first;

  assign out_free   = !out_valid_r || out_ch.ready;
  assign in_ready   = (state_r == ST_IDLE) && out_free;
  assign in_fire    = in_ch.valid && in_ready;
  assign is_read    = (in_ch.action == ACT_READ);
  assign rx_char    = (in_ch.char_in == CH_CR) ? CH_NL : in_ch.char_in;
  assign edit_inc   = pos_inc(edit_r);
  assign has_room   = pos_diff(edit_r, read_r) < (PW+1)'(RING_DEPTH);
  assign fills_ring = pos_diff(edit_inc, read_r) == (PW+1)'(RING_DEPTH);
  assign pending    = (edit_r != commit_r);
  assign ring_empty = (read_r == commit_r);
  assign kill_go    = pending && (ram_rdata != CH_NL) && (kill_cnt_r < NW'(RING_DEPTH));
  assign kill_first = (kill_cnt_r == '0);
  assign ram_raddr  = (state_r == ST_IDLE) ? pos_slot(read_r) : pos_slot(pos_dec(edit_r));

  ttyle_ram #(
    .WIDTH (CHAR_W),
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (pos_slot(edit_r)),
    .wdata (rx_char),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (is_read) begin
            if (!ring_empty) begin
              state_nxt = ST_RD_WAIT;
            end
          end else if (in_ch.char_in == CH_KILL) begin
            state_nxt = ST_KILL_ADDR;
          end
        end
      end
      ST_RD_WAIT: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_KILL_ADDR: begin
        state_nxt = ST_KILL_CHK;
      end
      ST_KILL_CHK: begin
        if (kill_go && (kill_first || out_free)) begin
          state_nxt = ST_KILL_ADDR;
        end else if (!kill_go && out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    read_nxt     = read_r;
    commit_nxt   = commit_r;
    edit_nxt     = edit_r;
    kill_cnt_nxt = kill_cnt_r;
    started_nxt  = started_r;
    ram_we       = 1'b0;
    load_out     = 1'b0;
    kind_nxt     = KIND_NONE;
    data_nxt     = '0;
    line_end_nxt = 1'b0;
    wake_nxt     = 1'b0;
    last_nxt     = 1'b1;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          started_nxt  = in_ch.read_started;
          kill_cnt_nxt = '0;
          if (is_read) begin
            if (ring_empty) begin
              load_out = 1'b1;
              kind_nxt = KIND_EMPTY;
            end
          end else if (in_ch.char_in == CH_INTR) begin
            load_out = 1'b1;
            kind_nxt = has_fg_r ? KIND_INTR : KIND_NONE;
          end else if (in_ch.char_in == CH_KILL) begin
            load_out = 1'b0;
          end else if ((in_ch.char_in == CH_BS) || (in_ch.char_in == CH_DEL)) begin
            load_out = 1'b1;
            if (pending) begin
              edit_nxt = pos_dec(edit_r);
              kind_nxt = KIND_ECHO;
              data_nxt = bs_code_r;
            end
          end else if ((in_ch.char_in != CH_NUL) && has_room) begin
            load_out = 1'b1;
            ram_we   = 1'b1;
            edit_nxt = edit_inc;
            kind_nxt = KIND_ECHO;
            data_nxt = rx_char;
            if ((rx_char == CH_NL) || (rx_char == CH_EOF) || fills_ring) begin
              commit_nxt = edit_inc;
              wake_nxt   = 1'b1;
            end
          end else begin
            load_out = 1'b1;
          end
        end
      end
      ST_RD_WAIT: begin
        if (out_free) begin
          load_out = 1'b1;
          if (ram_rdata == CH_EOF) begin
            kind_nxt = KIND_EOF;
            if (!started_r) begin
              read_nxt = pos_inc(read_r);
            end
          end else begin
            read_nxt     = pos_inc(read_r);
            kind_nxt     = KIND_BYTE;
            data_nxt     = ram_rdata;
            line_end_nxt = (ram_rdata == CH_NL);
          end
        end
      end
      ST_KILL_ADDR: begin
        load_out = 1'b0;
      end
      ST_KILL_CHK: begin
        if (kill_go) begin
          if (kill_first || out_free) begin
            edit_nxt     = pos_dec(edit_r);
            kill_cnt_nxt = kill_cnt_r + 1'b1;
            load_out     = !kill_first;
            kind_nxt     = KIND_ECHO;
            data_nxt     = bs_code_r;
            last_nxt     = 1'b0;
          end
        end else if (out_free) begin
          load_out = 1'b1;
          if (!kill_first) begin
            kind_nxt = KIND_ECHO;
            data_nxt = bs_code_r;
          end
        end
      end
      default: load_out = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      read_r      <= '0;
      commit_r    <= '0;
      edit_r      <= '0;
      kill_cnt_r  <= '0;
      started_r   <= 1'b0;
      bs_code_r   <= BS_CODE_RST;
      has_fg_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      read_r     <= read_nxt;
      commit_r   <= commit_nxt;
      edit_r     <= edit_nxt;
      kill_cnt_r <= kill_cnt_nxt;
      started_r  <= started_nxt;
      if (cfg_ch.valid) begin
        if (cfg_ch.index == REG_BS_CODE) begin
          bs_code_r <= cfg_ch.wdata;
        end else if (cfg_ch.index == REG_HAS_FG) begin
          has_fg_r <= cfg_ch.wdata[0];
        end
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_kind_r     <= kind_nxt;
      out_data_r     <= data_nxt;
      out_line_end_r <= line_end_nxt;
      out_wake_r     <= wake_nxt;
      out_last_r     <= last_nxt;
    end
  end

  assign in_ch.ready         = in_ready;
  assign cfg_ch.ready        = 1'b1;
  assign out_ch.valid        = out_valid_r;
  assign out_ch.kind         = out_kind_r;
  assign out_ch.data         = out_data_r;
  assign out_ch.line_end     = out_line_end_r;
  assign out_ch.wake_readers = out_wake_r;
  assign out_ch.last         = out_last_r;

endmodule

`default_nettype wire

FILE: hw/rtl/ttyle_ram.sv
// generic single write port ram with registered read
`default_nettype none

module ttyle_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

`default_nettype wire

FILE: hw/rtl/ttyle_chk.sv
// port-level checks for the tty line edit buffer and their bind
`default_nettype none

module ttyle_chk (
  input wire logic                   clk,
  input wire logic                   rst_n,
  input wire logic                   in_valid,
  input wire logic                   in_ready,
  input wire logic                   out_valid,
  input wire logic                   out_ready,
  input wire ttyle_pkg::kind_t       out_kind,
  input wire logic [ttyle_pkg::CHAR_W-1:0] out_data,
  input wire logic                   out_line_end,
  input wire logic                   out_wake,
  input wire logic                   out_last
);
  import ttyle_pkg::*;

  logic busy_r;
  logic in_fire;
  logic out_fire;

  assign in_fire  = in_valid && in_ready;
  assign out_fire = out_valid && out_ready;

  // one transaction in flight until its last result goes out
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (in_fire) begin
      busy_r <= 1'b1;
    end else if (out_fire && out_last) begin
      busy_r <= 1'b0;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |-> !busy_r || (out_fire && out_last))
    else $error("new transaction accepted before last result");

  a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy_r)
    else $error("result without an accepted transaction");

  a_quiet_kinds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == KIND_INTR || out_kind == KIND_EOF ||
                  out_kind == KIND_EMPTY || out_kind == KIND_NONE)
    |-> out_data == '0 && !out_line_end && !out_wake && out_last)
    else $error("payload on a result without data");

  a_wake_echo: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_wake |-> out_kind == KIND_ECHO && out_last)
    else $error("wake outside a committing echo");

endmodule

bind tty_line_edit_buffer_core ttyle_chk u_ttyle_chk (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .out_kind     (out_ch.kind),
  .out_data     (out_ch.data),
  .out_line_end (out_ch.line_end),
  .out_wake     (out_ch.wake_readers),
  .out_last     (out_ch.last)
);

`default_nettype wire
